// File: rtl/msl_pkg.sv
`timescale 1ns / 1ps

package msl_pkg;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam int CFG_W = 7;
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam int GROUPS = 8;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] col;
        logic [5:0] row;
        logic [2:0] kind;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in;

    typedef struct packed {
        logic [2:0] kind_out;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       tick_done;
    } t_out;

    typedef struct packed {
        logic clear;
        logic acc;
        logic commit;
    } t_rule_ctl;

endpackage

// File: rtl/msl_ram.sv
`timescale 1ns / 1ps

module msl_ram #(
    parameter int W = 27,
    parameter int D = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_addr,
    input  logic [W-1:0]         i_wdata,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// File: rtl/msl_rule.sv
`timescale 1ns / 1ps

module msl_rule #(
    parameter int SB = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msl_pkg::t_rule_ctl   i_ctl,
    input  logic [SB-1:0]        i_sp,
    input  msl_pkg::t_rgb        i_rgb,
    output logic [SB-1:0]        o_sp,
    output msl_pkg::t_rgb        o_rgb
);

    localparam int G = msl_pkg::GROUPS;

    logic [SB-1:0] r_gsp [G];
    logic [3:0]    r_gcnt [G];
    logic [10:0]   r_gr [G];
    logic [10:0]   r_gg [G];
    logic [10:0]   r_gb [G];
    logic [3:0]    r_ng;
    logic [15:0]   r_lfsr;

    logic [G-1:0]  hit;
    logic          any;
    logic [3:0]    same;
    logic          have0, have1;
    logic [2:0]    p0, p1, pick;
    logic [15:0]   n_lfsr;
    logic [19:0]   qr, qg, qb;

    always_comb begin
        any = 1'b0;
        same = '0;
        for (int i = 0; i < G; i++) begin
            hit[i] = (r_gcnt[i] != 4'd0) && (r_gsp[i] == i_sp);
            if (hit[i]) begin
                same = r_gcnt[i];
            end
        end
        any = |hit;
    end

    // first two groups of exactly three
    always_comb begin
        have0 = 1'b0;
        have1 = 1'b0;
        p0 = '0;
        p1 = '0;
        for (int i = 0; i < G; i++) begin
            if (r_gcnt[i] == 4'd3) begin
                if (!have0) begin
                    have0 = 1'b1;
                    p0 = 3'(i);
                end else if (!have1) begin
                    have1 = 1'b1;
                    p1 = 3'(i);
                end
            end
        end
        n_lfsr = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[15:1]};
        pick = (have1 && n_lfsr[0]) ? p1 : p0;
        // divide by three: sums here are at most 765
        qr = r_gr[pick][9:0] * 10'd683;
        qg = r_gg[pick][9:0] * 10'd683;
        qb = r_gb[pick][9:0] * 10'd683;
    end

    always_comb begin
        o_sp = '0;
        o_rgb = '0;
        if (i_sp != '0) begin
            if (same == 4'd2 || same == 4'd3) begin
                o_sp = i_sp;
                o_rgb = i_rgb;
            end
        end else if (have0) begin
            o_sp = r_gsp[pick];
            o_rgb.r = qr[18:11];
            o_rgb.g = qg[18:11];
            o_rgb.b = qb[18:11];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ng <= '0;
            r_lfsr <= msl_pkg::LFSR_SEED;
            for (int i = 0; i < G; i++) begin
                r_gcnt[i] <= '0;
            end
        end else begin
            if (i_ctl.clear) begin
                r_ng <= '0;
                for (int i = 0; i < G; i++) begin
                    r_gcnt[i] <= '0;
                end
            end else if (i_ctl.acc && i_sp != '0) begin
                for (int i = 0; i < G; i++) begin
                    if (hit[i]) begin
                        r_gcnt[i] <= r_gcnt[i] + 4'd1;
                        r_gr[i] <= r_gr[i] + 11'(i_rgb.r);
                        r_gg[i] <= r_gg[i] + 11'(i_rgb.g);
                        r_gb[i] <= r_gb[i] + 11'(i_rgb.b);
                    end else if (!any && 4'(i) == r_ng) begin
                        r_gsp[i] <= i_sp;
                        r_gcnt[i] <= 4'd1;
                        r_gr[i] <= 11'(i_rgb.r);
                        r_gg[i] <= 11'(i_rgb.g);
                        r_gb[i] <= 11'(i_rgb.b);
                    end
                end
                if (!any) begin
                    r_ng <= r_ng + 4'd1;
                end
            end
            if (i_ctl.commit && i_sp == '0 && have1) begin
                r_lfsr <= n_lfsr;
            end
        end
    end

endmodule

// File: rtl/multi_species_life_grid_step.sv
`timescale 1ns / 1ps

// Two-bank toroidal multi-species life grid. After reset both banks are
// cleared before the first item is taken. A write or read item first wraps
// col and row past the grid size in use back into the grid. A tick item
// walks every cell of the grid in use with nine reads of the single-port
// current bank plus the write to the other bank per cell. A result waits
// in an output register while the next item is taken.
module multi_species_life_grid_step #(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int SPECIES_BITS = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  msl_pkg::t_in                i_item,
    output logic                        o_valid,
    input  logic                        i_stall,
    output msl_pkg::t_out               o_res,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [msl_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW  = $clog2(CELLS);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int EXW = $clog2(MAX_WIDTH + 1);
    localparam int EYW = $clog2(MAX_HEIGHT + 1);
    localparam int SB  = SPECIES_BITS;
    localparam int DW  = SB + 24;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RED   = 7'b0000100,
        S_ACC   = 7'b0001000,
        S_RDW   = 7'b0010000,
        S_TICK  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    logic [msl_pkg::CFG_W-1:0] r_wcfg, r_hcfg;
    logic          r_bank;
    logic [AW-1:0] r_clr;
    logic [5:0]    r_cx, r_ry;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [3:0]    r_ph;
    msl_pkg::t_in  r_item;
    msl_pkg::t_out r_pend;
    msl_pkg::t_out r_res;
    logic          r_ov;

    logic [EXW-1:0] eff_w;
    logic [EYW-1:0] eff_h;
    logic [XW-1:0]  xm, xp, nx;
    logic [YW-1:0]  ym, yp, ny;
    logic [AW-1:0]  item_addr, self_addr, nb_addr;
    logic [DW-1:0]  rd0, rd1, cur;
    logic           we0, we1;
    logic [AW-1:0]  a0, a1;
    logic [DW-1:0]  wd0, wd1, item_wd, tick_wd;
    msl_pkg::t_rule_ctl ctl;
    logic [SB-1:0]  cur_sp, res_sp;
    msl_pkg::t_rgb  cur_rgb, res_rgb;
    logic           in_acc;
    logic           tick_wr;

    function automatic logic [AW-1:0] f_addr(input logic [AW-1:0] x, input logic [AW-1:0] y);
        return y * AW'(MAX_WIDTH) + x;
    endfunction

    always_comb begin
        if (r_wcfg == '0) begin
            eff_w = EXW'(1);
        end else if (int'(r_wcfg) > MAX_WIDTH) begin
            eff_w = EXW'(MAX_WIDTH);
        end else begin
            eff_w = EXW'(r_wcfg);
        end
        if (r_hcfg == '0) begin
            eff_h = EYW'(1);
        end else if (int'(r_hcfg) > MAX_HEIGHT) begin
            eff_h = EYW'(MAX_HEIGHT);
        end else begin
            eff_h = EYW'(r_hcfg);
        end
    end

    // wrapped neighbour coordinates
    always_comb begin
        xm = (r_x == '0) ? XW'(eff_w - EXW'(1)) : r_x - XW'(1);
        xp = (EXW'(r_x) + EXW'(1) == eff_w) ? '0 : r_x + XW'(1);
        ym = (r_y == '0) ? YW'(eff_h - EYW'(1)) : r_y - YW'(1);
        yp = (EYW'(r_y) + EYW'(1) == eff_h) ? '0 : r_y + YW'(1);
        case (r_ph)
            4'd0, 4'd1, 4'd2: nx = xm;
            4'd5, 4'd6, 4'd7: nx = xp;
            default:          nx = r_x;
        endcase
        case (r_ph)
            4'd0, 4'd3, 4'd5: ny = ym;
            4'd2, 4'd4, 4'd7: ny = yp;
            default:          ny = r_y;
        endcase
    end

    assign item_addr = f_addr(AW'(r_cx), AW'(r_ry));
    assign self_addr = f_addr(AW'(r_x), AW'(r_y));
    assign nb_addr   = f_addr(AW'(nx), AW'(ny));

    assign cur     = r_bank ? rd1 : rd0;
    assign cur_sp  = cur[DW-1:24];
    assign cur_rgb = cur[23:0];

    assign ctl.clear  = (r_state == S_TICK) && (r_ph == 4'd0);
    assign ctl.acc    = (r_state == S_TICK) && (r_ph >= 4'd1) && (r_ph <= 4'd8);
    assign ctl.commit = (r_state == S_TICK) && (r_ph == 4'd9);

    msl_rule #(.SB(SB)) u_rule (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_sp    (cur_sp),
        .i_rgb   (cur_rgb),
        .o_sp    (res_sp),
        .o_rgb   (res_rgb)
    );

    assign item_wd = {SB'(r_item.kind), r_item.red_in, r_item.green_in, r_item.blue_in};
    assign tick_wd = {res_sp, res_rgb};
    assign tick_wr = ctl.commit;

    // the current bank serves items and tick reads, the other one takes tick writes
    always_comb begin
        we0 = 1'b0;
        we1 = 1'b0;
        a0 = item_addr;
        a1 = item_addr;
        wd0 = item_wd;
        wd1 = item_wd;
        case (r_state)
            S_CLEAR: begin
                we0 = 1'b1;
                we1 = 1'b1;
                a0 = r_clr;
                a1 = r_clr;
                wd0 = '0;
                wd1 = '0;
            end
            S_ACC: begin
                we0 = (r_item.mode == msl_pkg::MODE_WRITE) && !r_bank;
                we1 = (r_item.mode == msl_pkg::MODE_WRITE) && r_bank;
            end
            S_TICK: begin
                if (r_bank) begin
                    a1 = nb_addr;
                    a0 = self_addr;
                    wd0 = tick_wd;
                    we0 = tick_wr;
                end else begin
                    a0 = nb_addr;
                    a1 = self_addr;
                    wd1 = tick_wd;
                    we1 = tick_wr;
                end
            end
            default: begin
            end
        endcase
    end

    msl_ram #(.W(DW), .D(CELLS)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_addr  (a0),
        .i_wdata (wd0),
        .o_rdata (rd0)
    );

    msl_ram #(.W(DW), .D(CELLS)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_addr  (a1),
        .i_wdata (wd1),
        .o_rdata (rd1)
    );

    assign in_acc  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_wcfg <= msl_pkg::CFG_W'(64);
            r_hcfg <= msl_pkg::CFG_W'(64);
            r_bank <= 1'b0;
            r_clr <= '0;
            r_ov <= 1'b0;
            r_ph <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == msl_pkg::CFG_WIDTH) begin
                    r_wcfg <= i_cfg_data;
                end else begin
                    r_hcfg <= i_cfg_data;
                end
            end
            if (r_state == S_OUT && (!r_ov || !i_stall)) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (int'(r_clr) == CELLS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_item <= i_item;
                        r_cx <= i_item.col;
                        r_ry <= i_item.row;
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    // one wrap per cycle until the address is inside the grid
                    if (EXW'(r_cx) >= eff_w || 6'(EXW'(r_cx)) != r_cx) begin
                        r_cx <= r_cx - 6'(eff_w);
                    end
                    if (EYW'(r_ry) >= eff_h || 6'(EYW'(r_ry)) != r_ry) begin
                        r_ry <= r_ry - 6'(eff_h);
                    end
                    if ((EXW'(r_cx) < eff_w && 6'(EXW'(r_cx)) == r_cx)
                            && (EYW'(r_ry) < eff_h && 6'(EYW'(r_ry)) == r_ry)) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_pend <= '0;
                    r_x <= '0;
                    r_y <= '0;
                    r_ph <= '0;
                    if (r_item.mode == msl_pkg::MODE_READ) begin
                        r_state <= S_RDW;
                    end else if (r_item.mode == msl_pkg::MODE_TICK) begin
                        r_state <= S_TICK;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_RDW: begin
                    r_pend.kind_out <= 3'(cur_sp);
                    r_pend.red_out <= cur_rgb.r;
                    r_pend.green_out <= cur_rgb.g;
                    r_pend.blue_out <= cur_rgb.b;
                    r_pend.tick_done <= 1'b0;
                    r_state <= S_OUT;
                end
                S_TICK: begin
                    if (r_ph == 4'd9) begin
                        r_ph <= '0;
                        if (EYW'(r_y) + EYW'(1) == eff_h) begin
                            r_y <= '0;
                            if (EXW'(r_x) + EXW'(1) == eff_w) begin
                                r_bank <= !r_bank;
                                r_pend.tick_done <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_x <= r_x + XW'(1);
                            end
                        end else begin
                            r_y <= r_y + YW'(1);
                        end
                    end else begin
                        r_ph <= r_ph + 4'd1;
                    end
                end
                S_OUT: begin
                    if (!r_ov || !i_stall) begin
                        r_res <= r_pend;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
